// File: rtl/first_fit_heap_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define FFHA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffha check failed");
`define FFHA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffha check failed");
`else
`define FFHA_ASSERT_IMP(lbl, ante, cons)
`define FFHA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared widths, codes and types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEAP_BYTES_DEF = 65536;
	localparam int TAG_W          = 18;
	localparam int PADDR_W        = 3;
	localparam logic [16:0] OVH_BYTES = 17'd40;
	localparam logic [16:0] HDR_BYTES = 17'd32;
	localparam logic [15:0] THR_RESET = 16'd1024;
	localparam logic [16:0] LIM_RESET = 17'd65536;

	localparam logic [1:0] FN_ALLOC   = 2'd0;
	localparam logic [1:0] FN_FREE    = 2'd1;
	localparam logic [1:0] FN_REALLOC = 2'd2;
	localparam logic [1:0] FN_RSVD    = 2'd3;

	localparam logic REG_THR = 1'b0;
	localparam logic REG_LIM = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OOM   = 2'd1,
		ST_BAD   = 2'd2,
		ST_FREED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_RD,
		S_A_CHK,
		S_A_SPLIT,
		S_L_RD,
		S_L_CHK,
		S_F_PREV,
		S_F_PRD,
		S_F_PHD,
		S_F_NEXT,
		S_F_NHD,
		S_F_MERGE,
		S_DONE
	} fsm_t;

endpackage

// File: rtl/ffha_if.sv
// ----------------------------------------------------------------------------
// ffha request and response channels
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
interface ffha_req_if import ffha_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] req_bytes;
	logic [15:0] ptr_addr;

	modport source (output valid, func, req_bytes, ptr_addr, input ready);
	modport sink (input valid, func, req_bytes, ptr_addr, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] result_addr;

	modport source (output valid, status, result_addr, input ready);
	modport sink (input valid, status, result_addr, output ready);
endinterface

// File: rtl/first_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit boundary-tag heap allocator over a header and a footer memory.
// ----------------------------------------------------------------------------
// Usage:
// - req channel (valid/ready) carries func, req_bytes and ptr_addr; a beat is
//   taken only while the sequencer is idle. rsp channel returns one beat per
//   request with status and result_addr.
// - Allocate walks blocks from offset 0 in address order, reading each
//   block's header and then checking it. Growth at the heap top is written
//   from the header-read state; a split adds a state for the remainder. Free
//   locates the block by the same walk, then reads the previous and next
//   neighbours' tags and merges them. Reallocate is locate + allocate walk +
//   free; the walk is paced by the registered header memory read port.
// - The result sits in an output register; a new request is taken while it
//   waits. A stalled receiver holds the next result in the done state.
// - Reset clears the heap top (empty heap) and loads the register defaults;
//   the memories need no clearing since only written entries are read.
// - Configuration (APB, register 0 split_threshold, 4 heap_limit) must be
//   written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_top_macros.svh"

module first_fit_heap_allocator_top import ffha_pkg::*; #(
	parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	ffha_req_if.sink           req,
	ffha_rsp_if.source         rsp
);

	localparam int DEPTH = HEAP_BYTES / 16;
	localparam int IW    = $clog2(DEPTH);
	localparam int CAP_I = (DEPTH * 16 > 65536) ? 65536 : DEPTH * 16;
	localparam logic [16:0] CAP = 17'(CAP_I);

	function automatic logic [IW-1:0] blk_idx(input logic [16:0] ofs);
		return IW'(ofs >> 4);
	endfunction

	// registers
	logic [15:0] thr_q;
	logic [16:0] lim_q;
	fsm_t        state_q, state_d;
	logic        realloc_q, ptr_lo_q;
	logic [16:0] need_q, walk_q, top_q, blk_q, bsz_q;
	logic [15:0] target_q;
	logic [16:0] pb_q, nb_q, nend_q, sp_base_q, sp_size_q;
	logic        pfree_q, nfree_q;
	status_t     res_st_q;
	logic [15:0] res_addr_q;
	logic        out_valid_q;
	status_t     out_st_q;
	logic [15:0] out_addr_q;

	// memory ports
	logic             hdr_we, ftr_we;
	logic [IW-1:0]    hdr_waddr, ftr_waddr, hdr_raddr, ftr_raddr;
	logic [TAG_W-1:0] hdr_wdata, hdr_rdata;
	logic [16:0]      ftr_wdata, ftr_rdata;

	ffha_ram #(.WIDTH(TAG_W), .DEPTH(DEPTH)) u_hdr (
		.clk(clk), .we(hdr_we), .waddr(hdr_waddr), .wdata(hdr_wdata),
		.raddr(hdr_raddr), .rdata(hdr_rdata)
	);

	ffha_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_ftr (
		.clk(clk), .we(ftr_we), .waddr(ftr_waddr), .wdata(ftr_wdata),
		.raddr(ftr_raddr), .rdata(ftr_rdata)
	);

	// config port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_LIM) ? {15'd0, lim_q} : {16'd0, thr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			lim_q <= LIM_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_THR) begin
				thr_q <= pwdata[15:0];
			end else begin
				lim_q <= pwdata[16:0];
			end
		end
	end

	// shared datapath terms
	logic        acc, out_free, hdr_free;
	logic [16:0] hdr_size, lim, step, nb_comb, pb_comb;
	logic [17:0] grow_sum, split_lim;
	logic        walk_lt_top, grow_ok, fit, do_split, loc_ok, prev_ok;
	logic [16:0] m_base, m_end, m_size;
	logic [16:0] tot_c;

	assign acc       = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign hdr_free  = hdr_rdata[TAG_W-1];
	assign hdr_size  = hdr_rdata[16:0];
	assign lim       = (lim_q > CAP) ? CAP : lim_q;
	assign tot_c     = ((17'(req.req_bytes) + 17'd55) >> 4) << 4;

	assign walk_lt_top = walk_q < top_q;
	assign grow_sum    = {1'b0, top_q} + {1'b0, need_q} + 18'd40;
	assign grow_ok     = grow_sum <= {1'b0, lim};
	assign fit         = hdr_free && (hdr_size >= need_q);
	assign split_lim   = {2'b0, thr_q} + {1'b0, need_q} + 18'd40;
	assign do_split    = (hdr_size > need_q) && ({1'b0, hdr_size} >= split_lim);
	assign step        = walk_q + hdr_size + OVH_BYTES;
	assign loc_ok      = walk_lt_top && !ptr_lo_q && (walk_q <= {1'b0, target_q});
	assign nb_comb     = blk_q + bsz_q + OVH_BYTES;
	assign prev_ok     = ({1'b0, ftr_rdata} + 18'd40) <= {1'b0, blk_q};
	assign pb_comb     = blk_q - ftr_rdata - OVH_BYTES;

	// merge target: prev block absorbs us, and/or we absorb next
	assign m_base = pfree_q ? pb_q : blk_q;
	assign m_end  = nfree_q ? nend_q : nb_q;
	assign m_size = m_end - m_base - OVH_BYTES;

	// next state and memory controls
	always_comb begin
		state_d   = state_q;
		hdr_we    = 1'b0;
		ftr_we    = 1'b0;
		hdr_waddr = blk_idx(walk_q);
		hdr_wdata = {1'b0, need_q};
		ftr_waddr = blk_idx(walk_q);
		ftr_wdata = need_q;
		hdr_raddr = blk_idx(walk_q);
		ftr_raddr = blk_idx(blk_q) - IW'(1);
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.func)
						FN_ALLOC: state_d = (req.req_bytes == 16'd0) ? S_DONE : S_A_RD;
						FN_FREE:  state_d = (req.ptr_addr == 16'd0) ? S_DONE : S_L_RD;
						FN_REALLOC: begin
							if (req.ptr_addr == 16'd0) begin
								state_d = (req.req_bytes == 16'd0) ? S_DONE : S_A_RD;
							end else begin
								state_d = S_L_RD;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_A_RD: begin
				if (walk_lt_top) begin
					state_d = S_A_CHK;
				end else if (grow_ok) begin
					// append a new block at the heap top
					hdr_we    = 1'b1;
					hdr_waddr = blk_idx(top_q);
					hdr_wdata = {1'b0, need_q};
					ftr_we    = 1'b1;
					ftr_waddr = blk_idx(grow_sum[16:0]) - IW'(1);
					ftr_wdata = need_q;
					state_d   = realloc_q ? S_F_PREV : S_DONE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_A_CHK: begin
				if (fit) begin
					hdr_we    = 1'b1;
					hdr_waddr = blk_idx(walk_q);
					if (do_split) begin
						hdr_wdata = {1'b0, need_q};
						ftr_we    = 1'b1;
						ftr_waddr = blk_idx(walk_q + need_q + OVH_BYTES) - IW'(1);
						ftr_wdata = need_q;
						state_d   = S_A_SPLIT;
					end else begin
						hdr_wdata = {1'b0, hdr_size};
						state_d   = realloc_q ? S_F_PREV : S_DONE;
					end
				end else begin
					state_d = S_A_RD;
				end
			end
			S_A_SPLIT: begin
				hdr_we    = 1'b1;
				hdr_waddr = blk_idx(sp_base_q);
				hdr_wdata = {1'b1, sp_size_q};
				ftr_we    = 1'b1;
				ftr_waddr = blk_idx(sp_base_q + sp_size_q + OVH_BYTES) - IW'(1);
				ftr_wdata = sp_size_q;
				state_d   = realloc_q ? S_F_PREV : S_DONE;
			end
			S_L_RD: begin
				state_d = loc_ok ? S_L_CHK : S_DONE;
			end
			S_L_CHK: begin
				if (walk_q == {1'b0, target_q}) begin
					if (hdr_free) begin
						state_d = S_DONE;
					end else begin
						state_d = realloc_q ? S_A_RD : S_F_PREV;
					end
				end else begin
					state_d = S_L_RD;
				end
			end
			S_F_PREV: begin
				state_d = (blk_q != 17'd0) ? S_F_PRD : S_F_NEXT;
			end
			S_F_PRD: begin
				hdr_raddr = blk_idx(pb_comb);
				state_d   = prev_ok ? S_F_PHD : S_F_NEXT;
			end
			S_F_PHD: begin
				state_d = S_F_NEXT;
			end
			S_F_NEXT: begin
				hdr_raddr = blk_idx(nb_comb);
				state_d   = (nb_comb < top_q) ? S_F_NHD : S_F_MERGE;
			end
			S_F_NHD: begin
				state_d = S_F_MERGE;
			end
			S_F_MERGE: begin
				hdr_we    = 1'b1;
				hdr_waddr = blk_idx(m_base);
				hdr_wdata = {1'b1, m_size};
				ftr_we    = 1'b1;
				ftr_waddr = blk_idx(m_end) - IW'(1);
				ftr_wdata = m_size;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// heap top and walk datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
		end else if (state_q == S_A_RD && !walk_lt_top && grow_ok) begin
			top_q <= grow_sum[16:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				need_q     <= tot_c - OVH_BYTES;
				walk_q     <= '0;
				target_q   <= req.ptr_addr - 16'd32;
				ptr_lo_q   <= req.ptr_addr < 16'd32;
				realloc_q  <= (req.func == FN_REALLOC) && (req.ptr_addr != 16'd0)
				              && (req.req_bytes != 16'd0);
				res_st_q   <= ST_OK;
				res_addr_q <= '0;
			end
			S_A_RD: begin
				if (!walk_lt_top) begin
					if (grow_ok) begin
						res_addr_q <= 16'(top_q + HDR_BYTES);
					end else begin
						res_st_q <= ST_OOM;
					end
				end
			end
			S_A_CHK: begin
				if (fit) begin
					res_addr_q <= 16'(walk_q + HDR_BYTES);
					sp_base_q  <= walk_q + need_q + OVH_BYTES;
					sp_size_q  <= hdr_size - need_q - OVH_BYTES;
				end else begin
					walk_q <= step;
				end
			end
			S_L_RD: begin
				if (!loc_ok) begin
					res_st_q <= ST_BAD;
				end
			end
			S_L_CHK: begin
				if (walk_q == {1'b0, target_q}) begin
					blk_q  <= walk_q;
					bsz_q  <= hdr_size;
					walk_q <= '0;
					if (hdr_free) begin
						res_st_q <= ST_FREED;
					end
				end else begin
					walk_q <= step;
				end
			end
			S_F_PREV: begin
				pfree_q <= 1'b0;
				nfree_q <= 1'b0;
			end
			S_F_PRD: begin
				pb_q <= pb_comb;
			end
			S_F_PHD: begin
				pfree_q <= hdr_free;
			end
			S_F_NEXT: begin
				nb_q <= nb_comb;
			end
			S_F_NHD: begin
				nfree_q <= hdr_free;
				nend_q  <= nb_q + hdr_size + OVH_BYTES;
			end
			default: begin
			end
		endcase
	end

	// output register: hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_st_q   <= res_st_q;
			out_addr_q <= (res_st_q == ST_OK) ? res_addr_q : 16'd0;
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_st_q;
	assign rsp.result_addr = out_addr_q;

	// checks
	`FFHA_ASSERT_IMP(a_top_bound, 1'b1, (top_q <= CAP) && (top_q[3:0] == 4'd0))
	`FFHA_ASSERT_IMP(a_err_null, rsp.valid && (rsp.status != ST_OK), rsp.result_addr == 16'd0)
	`FFHA_ASSERT_IMP(a_walk_align, state_q == S_A_CHK || state_q == S_L_CHK, walk_q[3:0] == 4'd0)
	`FFHA_ASSERT_NXT(a_busy_after_take, acc, state_q != S_IDLE)

endmodule

// File: rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram
// Single write port, single registered read port memory.
// ----------------------------------------------------------------------------
module ffha_ram import ffha_pkg::*; #(
	parameter int WIDTH = TAG_W,
	parameter int DEPTH = HEAP_BYTES_DEF / 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
